FILE: design/ddq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the double-ended queue
// no dependencies
package ddq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int HELD_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic take_left;
    logic take_right;
    logic take_push;
  } cell_ctl_t;

endpackage

FILE: design/ddq_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces for the double-ended queue
// depends on ddq_pkg
interface ddq_req_if import ddq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [KIND_W-1:0] kind;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, kind, push_value, input ready);
  modport sink (input valid, kind, push_value, output ready);
endinterface

interface ddq_rsp_if import ddq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic        [STAT_W-1:0] status;
  logic        [HELD_W-1:0] held_count;
  logic                     is_empty;

  modport source (output valid, popped_value, status, held_count, is_empty, input ready);
  modport sink (input valid, popped_value, status, held_count, is_empty, output ready);
endinterface

FILE: design/double_ended_queue.sv
`timescale 1ns / 1ps
// double-ended queue top level: a row of shifting cells plus a count register
// result registered in the cycle after the request is accepted
// throughput: one item per cycle while the response side is ready to take results
// reset: count and response valid cleared, cell contents left undefined
// depends on ddq_pkg, ddq_if, ddq_cell
module double_ended_queue import ddq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ddq_req_if.sink   req,
  ddq_rsp_if.source rsp
);

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  cell_ctl_t                cell_ctl  [DEPTH];

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         tail_sel;
  logic [IDX_W-1:0]         back_idx;
  logic [IDX_W-1:0]         push_idx;
  logic                     accept;
  logic                     full;
  logic                     empty;
  logic signed [DATA_W-1:0] popped_next;
  status_t                  status_next;
  logic                     shift_right;
  logic                     shift_left;
  logic                     load_back;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign tail_sel  = count - CNT_W'(1);
  assign back_idx  = tail_sel[IDX_W-1:0];
  assign push_idx  = count[IDX_W-1:0];

  always_comb begin
    count_next  = count;
    popped_next = '0;
    status_next = ST_OK;
    shift_right = 1'b0;
    shift_left  = 1'b0;
    load_back   = 1'b0;
    case (req.kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          shift_right = 1'b1;
          count_next  = count + CNT_W'(1);
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          load_back  = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          popped_next = cell_data[0];
          shift_left  = 1'b1;
          count_next  = tail_sel;
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          popped_next = cell_data[back_idx];
          count_next  = tail_sel;
        end
      end
      KIND_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic signed [DATA_W-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_data = req.push_value;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    assign cell_ctl[i].take_left  = accept && shift_right;
    assign cell_ctl[i].take_right = accept && shift_left;
    assign cell_ctl[i].take_push  = accept && load_back && (push_idx == IDX_W'(i));

    ddq_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .left_data  (left_data),
      .right_data (right_data),
      .push_value (req.push_value),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.popped_value <= popped_next;
      rsp.status       <= status_next;
      rsp.held_count   <= HELD_W'(count_next);
      rsp.is_empty     <= (count_next == '0);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted item gave no result");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.is_empty == (rsp.held_count == '0)))
    else $error("empty flag disagrees with count");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && full && (req.kind == KIND_PUSH_FRONT || req.kind == KIND_PUSH_BACK))
      |=> (rsp.status == ST_FULL) && $stable(count))
    else $error("push on full queue not rejected");

endmodule

FILE: design/ddq_cell.sv
`timescale 1ns / 1ps
// one storage cell of the queue row, loads from a neighbor or the pushed item
// depends on ddq_pkg
module ddq_cell import ddq_pkg::*; (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic signed [DATA_W-1:0] push_value,
  output logic signed [DATA_W-1:0] data
);

  always_ff @(posedge clk) begin
    if (ctl.take_left) begin
      data <= left_data;
    end else if (ctl.take_right) begin
      data <= right_data;
    end else if (ctl.take_push) begin
      data <= push_value;
    end
  end

endmodule
